// ===== design/rla_pkg.sv =====
// rla_pkg: shared types and constants of the receive line assembler.
// Used by rla_front, rla_back and rx_line_assembler_top. No dependencies.

package rla_pkg;

  // Default line store size in bytes (one bank)
  localparam int BUF_BYTES_DEF = 64;

  // Line terminators
  localparam logic [7:0] CHR_CR = 8'h0D;
  localparam logic [7:0] CHR_LF = 8'h0A;

  // Field widths of the stream beats
  localparam int FUNC_W    = 2;
  localparam int BYTE_W    = 8;
  localparam int EVENT_W   = 3;
  localparam int OUT_LEN_W = 6;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 16;

  // Input item kind
  typedef enum logic [FUNC_W-1:0] {
    FN_BYTE  = 2'd0,
    FN_TAKE  = 2'd1,
    FN_CLEAR = 2'd2
  } func_t;

  // Result event codes
  typedef enum logic [EVENT_W-1:0] {
    EV_STORED    = 3'd0,
    EV_HELD      = 3'd1,
    EV_DROPPED   = 3'd2,
    EV_EMPTY     = 3'd3,
    EV_LINE_BYTE = 3'd4,
    EV_NONE      = 3'd5,
    EV_CLEARED   = 3'd6,
    EV_IGNORED   = 3'd7
  } event_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_DATA
  } back_state_t;

endpackage

// ===== design/rla_ram.sv =====
// rla_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module rla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rla_cmd_queue.sv =====
// rla_cmd_queue: two-entry command queue between front and back end.
// No dependencies.

module rla_cmd_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entry[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/rla_front.sv =====
// rla_front: accepts items, assembles bytes into the line RAM and classifies
// each item into a command for the back end. Depends on rla_pkg.

module rla_front
  import rla_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [FUNC_W-1:0]               in_func,
  input  logic [BYTE_W-1:0]               in_byte,
  // configuration
  input  logic                            cfg_we,
  input  logic                            cfg_wdata,
  // line RAM write port
  output logic                            ram_we,
  output logic [$clog2(BUF_BYTES):0]      ram_waddr,
  output logic [BYTE_W-1:0]               ram_wdata,
  // command queue
  output logic                            cmd_push,
  output logic [$clog2(BUF_BYTES)+4:0]    cmd_data,
  input  logic                            cmd_full,
  // back end finished streaming a held line
  input  logic                            stream_done
);

  localparam int PTR_W = $clog2(BUF_BYTES);
  localparam logic [PTR_W-1:0] FILL_LIMIT = PTR_W'(BUF_BYTES - 1);

  logic             rx_enable;
  logic [PTR_W-1:0] fill;
  logic [PTR_W-1:0] fill_next;
  logic             bank;
  logic             bank_next;
  logic             held_valid;
  logic             held_valid_next;
  logic             held_bank;
  logic             held_bank_next;
  logic [PTR_W-1:0] held_len;
  logic [PTR_W-1:0] held_len_next;
  logic             line_busy;
  logic             line_busy_next;

  logic             accept;
  logic             term;
  logic [PTR_W-1:0] fill_inc;
  logic             line_end;
  logic             cmd_is_line;
  logic             cmd_bank;
  logic [PTR_W-1:0] cmd_len;
  event_t           cmd_ev;

  // No new item while a held line is being streamed out
  assign in_ready = !cmd_full && !line_busy;
  assign accept   = in_valid && in_ready;

  assign term     = (in_byte == CHR_CR) || (in_byte == CHR_LF);
  assign fill_inc = fill + PTR_W'(1);
  assign line_end = term || (fill_inc == FILL_LIMIT);

  assign ram_waddr = {bank, fill};
  assign ram_wdata = in_byte;
  assign cmd_push  = accept;
  assign cmd_data  = {cmd_is_line, cmd_bank, cmd_len, cmd_ev};

  // Item classification and assembler update
  always_comb begin
    fill_next       = fill;
    bank_next       = bank;
    held_valid_next = held_valid;
    held_bank_next  = held_bank;
    held_len_next   = held_len;
    line_busy_next  = line_busy;
    ram_we          = 1'b0;
    cmd_is_line     = 1'b0;
    cmd_bank        = 1'b0;
    cmd_len         = '0;
    cmd_ev          = EV_IGNORED;

    if (stream_done) begin
      line_busy_next = 1'b0;
    end

    if (accept) begin
      unique case (func_t'(in_func))
        FN_BYTE: begin
          if (rx_enable) begin
            ram_we = 1'b1;
            if (line_end) begin
              fill_next = '0;
              if (fill_inc > PTR_W'(1) || !term) begin
                if (!held_valid) begin
                  // hand the bank over to the hold, assemble in the other
                  held_valid_next = 1'b1;
                  held_bank_next  = bank;
                  held_len_next   = term ? fill : fill_inc;
                  bank_next       = ~bank;
                  cmd_ev          = EV_HELD;
                  cmd_len         = term ? fill : fill_inc;
                end else begin
                  cmd_ev = EV_DROPPED;
                end
              end else begin
                cmd_ev = EV_EMPTY;
              end
            end else begin
              fill_next = fill_inc;
              cmd_ev    = EV_STORED;
            end
          end
        end
        FN_TAKE: begin
          if (held_valid) begin
            cmd_is_line     = 1'b1;
            cmd_bank        = held_bank;
            cmd_len         = held_len;
            cmd_ev          = EV_LINE_BYTE;
            held_valid_next = 1'b0;
            line_busy_next  = 1'b1;
          end else begin
            cmd_ev = EV_NONE;
          end
        end
        FN_CLEAR: begin
          fill_next       = '0;
          held_valid_next = 1'b0;
          cmd_ev          = EV_CLEARED;
        end
        default: cmd_ev = EV_IGNORED;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable  <= 1'b0;
      fill       <= '0;
      bank       <= 1'b0;
      held_valid <= 1'b0;
      held_bank  <= 1'b0;
      held_len   <= '0;
      line_busy  <= 1'b0;
    end else begin
      if (cfg_we) begin
        rx_enable <= cfg_wdata;
      end
      fill       <= fill_next;
      bank       <= bank_next;
      held_valid <= held_valid_next;
      held_bank  <= held_bank_next;
      held_len   <= held_len_next;
      line_busy  <= line_busy_next;
    end
  end

endmodule

// ===== design/rla_back.sv =====
// rla_back: pops commands and drives the result register; streams a held
// line out of the line RAM byte by byte, each a read then a result load. Depends on rla_pkg.

module rla_back
  import rla_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // command queue
  input  logic                            cmd_valid,
  input  logic [$clog2(BUF_BYTES)+4:0]    cmd_data,
  output logic                            cmd_pop,
  // line RAM read port
  output logic                            ram_re,
  output logic [$clog2(BUF_BYTES):0]      ram_raddr,
  input  logic [BYTE_W-1:0]               ram_rdata,
  // result stream
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [EVENT_W-1:0]              out_event,
  output logic [BYTE_W-1:0]               out_byte,
  output logic [OUT_LEN_W-1:0]            out_len,
  output logic                            out_last,
  // last byte of a held line loaded
  output logic                            stream_done
);

  localparam int PTR_W = $clog2(BUF_BYTES);

  back_state_t      state;
  back_state_t      state_next;
  logic             bank;
  logic             bank_next;
  logic [PTR_W-1:0] len;
  logic [PTR_W-1:0] len_next;
  logic [PTR_W-1:0] idx;
  logic [PTR_W-1:0] idx_next;

  logic             c_is_line;
  logic             c_bank;
  logic [PTR_W-1:0] c_len;
  logic [EVENT_W-1:0] c_ev;

  logic             out_free;
  logic             load;
  logic [EVENT_W-1:0]   load_event;
  logic [BYTE_W-1:0]    load_byte;
  logic [OUT_LEN_W-1:0] load_len;
  logic                 load_last;
  logic             idx_is_last;

  assign {c_is_line, c_bank, c_len, c_ev} = cmd_data;
  assign out_free    = !out_valid || out_ready;
  assign idx_is_last = ((idx + PTR_W'(1)) == len);
  assign ram_raddr   = {bank, idx};

  // Sequencer: next state and result load
  always_comb begin
    state_next  = state;
    bank_next   = bank;
    len_next    = len;
    idx_next    = idx;
    cmd_pop     = 1'b0;
    ram_re      = 1'b0;
    stream_done = 1'b0;
    load        = 1'b0;
    load_event  = EV_IGNORED;
    load_byte   = '0;
    load_len    = '0;
    load_last   = 1'b1;

    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          if (c_is_line) begin
            bank_next  = c_bank;
            len_next   = c_len;
            idx_next   = '0;
            state_next = BK_READ;
          end else begin
            load       = 1'b1;
            load_event = c_ev;
            load_len   = OUT_LEN_W'(c_len);
          end
        end
      end
      BK_READ: begin
        ram_re     = 1'b1;
        state_next = BK_DATA;
      end
      BK_DATA: begin
        if (out_free) begin
          load       = 1'b1;
          load_event = EV_LINE_BYTE;
          load_byte  = ram_rdata;
          load_len   = OUT_LEN_W'(len);
          load_last  = idx_is_last;
          if (idx_is_last) begin
            stream_done = 1'b1;
            state_next  = BK_IDLE;
          end else begin
            idx_next   = idx + PTR_W'(1);
            state_next = BK_READ;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    bank <= bank_next;
    len  <= len_next;
    idx  <= idx_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_event <= load_event;
      out_byte  <= load_byte;
      out_len   <= load_len;
      out_last  <= load_last;
    end
  end

endmodule

// ===== design/rx_line_assembler_top.sv =====
// Receive line assembler: every item but a take of a held line gives one result beat
// via the command queue and result register; one such item per cycle unless the queue
// is full or results stall. A take of a held line of n bytes gives n beats (each a line
// RAM read, then a result register load); input is held off until the last is loaded.
// Reset (rst, synchronous) clears fill, hold and rx_enable; the line RAM is
// not cleared and needs no clearing pass. Depends on rla_pkg and submodules.

module rx_line_assembler_top
  import rla_pkg::*;
#(
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte
  input  logic [FUNC_W-1:0]   s_axis_tuser,  // [1:0] func
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata,  // [7:0] data_byte, [13:8] line_length,
                                             // rest zero
  output logic [EVENT_W-1:0]  m_axis_tuser,  // [2:0] event_res
  output logic                m_axis_tlast,  // last
  // rx_enable register
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  localparam int PTR_W  = $clog2(BUF_BYTES);
  localparam int ADDR_W = PTR_W + 1;
  localparam int CMD_W  = PTR_W + 5;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [BYTE_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [BYTE_W-1:0]    ram_rdata;
  logic                 cmd_push;
  logic [CMD_W-1:0]     cmd_push_data;
  logic                 cmd_full;
  logic                 cmd_pop;
  logic                 cmd_valid;
  logic [CMD_W-1:0]     cmd_pop_data;
  logic                 stream_done;
  logic [BYTE_W-1:0]    out_byte;
  logic [OUT_LEN_W-1:0] out_len;

  assign m_axis_tdata = {{(M_DATA_W - BYTE_W - OUT_LEN_W){1'b0}}, out_len, out_byte};

  // Front end: accept and classify
  rla_front #(
    .BUF_BYTES (BUF_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_func     (s_axis_tuser),
    .in_byte     (s_axis_tdata[BYTE_W-1:0]),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .cmd_push    (cmd_push),
    .cmd_data    (cmd_push_data),
    .cmd_full    (cmd_full),
    .stream_done (stream_done)
  );

  // Two banks: one assembling, one holding a finished line
  rla_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (2 << PTR_W)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rla_cmd_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_push_data),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .not_empty (cmd_valid),
    .pop_data  (cmd_pop_data)
  );

  // Back end: results and line streaming
  rla_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_data    (cmd_pop_data),
    .cmd_pop     (cmd_pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_event   (m_axis_tuser),
    .out_byte    (out_byte),
    .out_len     (out_len),
    .out_last    (m_axis_tlast),
    .stream_done (stream_done)
  );

endmodule
